// File: hw/rtl/scx3_pkg.sv
// Shared types and constants for the Scale3x pixel upscaler.
package scx3_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [8:0]  FRAME_WIDTH_RESET  = 9'd128;
    localparam logic [10:0] FRAME_HEIGHT_RESET = 11'd64;

    localparam int PADDR_W = 3;

    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [7:0] pix_t;

    typedef struct packed {
        logic op;
        pix_t pixel;
    } in_word_t;

    typedef struct packed {
        pix_t       out_top_left;
        pix_t       out_top_mid;
        pix_t       out_top_right;
        pix_t       out_mid_left;
        pix_t       out_center;
        pix_t       out_mid_right;
        pix_t       out_bot_left;
        pix_t       out_bot_mid;
        pix_t       out_bot_right;
        logic [9:0] center_row;
        logic [7:0] center_col;
        logic       frame_last;
    } out_word_t;

    // masked 3x3 neighbourhood, a b c / d e f / g h i
    typedef struct packed {
        pix_t       a;
        pix_t       b;
        pix_t       c;
        pix_t       d;
        pix_t       e;
        pix_t       f;
        pix_t       g;
        pix_t       h;
        pix_t       i;
        logic [9:0] center_row;
        logic [7:0] center_col;
        logic       frame_last;
    } nbhd_t;

    typedef struct packed {
        logic  valid;
        nbhd_t data;
    } q_push_t;

    typedef struct packed {
        logic              head_valid;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

endpackage

// File: hw/rtl/scx3_front.sv
// Front end: frame counters, line buffer memory and 3x3 window.
module scx3_front
    import scx3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [8:0]  frame_width,
    input  logic [10:0] frame_height,
    input  logic        restart,
    input  logic        push,
    output logic        full,
    input  in_word_t    din,
    input  q_stat_t     q_stat,
    output q_push_t     q_push
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    logic [AW-1:0] w_m1;
    logic [RW-1:0] h_m1;

    logic [AW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [AW-1:0] ecol_reg;
    logic [RW-1:0] erow_reg;

    logic          accept;
    logic          pix_phase;
    logic          proc;
    logic          emit;
    logic          last_e;
    logic [31:0]   row_ext;
    logic [31:0]   col_ext;

    logic          stb_valid_reg;
    logic          stb_emit_reg;
    logic [AW-1:0] stb_q_reg;
    pix_t          stb_sample_reg;
    logic [9:0]    stb_row_reg;
    logic [7:0]    stb_col_reg;
    logic          stb_last_reg;
    logic          stb_top_reg;
    logic          stb_bot_reg;
    logic          stb_left_reg;
    logic          stb_right_reg;
    logic          stb_fwd_reg;
    logic [15:0]   fwd_data_reg;

    logic [15:0]   lb_mem [MAX_WIDTH];
    logic [15:0]   rd_reg;
    logic [15:0]   lb_word;
    logic [15:0]   wr_data;

    pix_t          win_reg  [9];
    pix_t          win_next [9];

    always_comb
    begin
        if (frame_width == '0)
            w_m1 = '0;
        else if (32'(frame_width) > MAX_WIDTH)
            w_m1 = AW'(MAX_WIDTH - 1);
        else
            w_m1 = AW'(frame_width - 9'd1);

        if (frame_height == '0)
            h_m1 = '0;
        else if (32'(frame_height) > MAX_HEIGHT)
            h_m1 = RW'(MAX_HEIGHT - 1);
        else
            h_m1 = RW'(frame_height - 11'd1);
    end

    assign full = ({1'b0, q_stat.count} + (QCNT_W + 1)'(stb_emit_reg))
                  >= (QCNT_W + 1)'(QUEUE_DEPTH);

    assign accept    = push && !full;
    assign pix_phase = (row_reg <= h_m1);
    assign proc      = accept && !(pix_phase && (din.op == OP_FLUSH));
    // first W+1 items of a frame only prime the buffers
    assign emit      = (row_reg > RW'(1)) || ((row_reg == RW'(1)) && (col_reg != '0));
    assign last_e    = (erow_reg == h_m1) && (ecol_reg == w_m1);
    assign row_ext   = 32'(erow_reg);
    assign col_ext   = 32'(ecol_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            ecol_reg <= '0;
            erow_reg <= '0;
        end
        else if (restart)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            ecol_reg <= '0;
            erow_reg <= '0;
        end
        else if (proc)
        begin
            if (emit && last_e)
            begin
                col_reg  <= '0;
                row_reg  <= '0;
                ecol_reg <= '0;
                erow_reg <= '0;
            end
            else
            begin
                if (col_reg == w_m1)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_reg + AW'(1);
                end
                if (emit)
                begin
                    if (ecol_reg == w_m1)
                    begin
                        ecol_reg <= '0;
                        erow_reg <= erow_reg + RW'(1);
                    end
                    else
                    begin
                        ecol_reg <= ecol_reg + AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stb_valid_reg <= 1'b0;
            stb_emit_reg  <= 1'b0;
        end
        else
        begin
            stb_valid_reg <= proc;
            stb_emit_reg  <= proc && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            stb_q_reg      <= col_reg;
            stb_sample_reg <= pix_phase ? din.pixel : '0;
            stb_row_reg    <= row_ext[9:0];
            stb_col_reg    <= col_ext[7:0];
            stb_last_reg   <= last_e;
            stb_top_reg    <= (erow_reg == '0);
            stb_bot_reg    <= (erow_reg == h_m1);
            stb_left_reg   <= (ecol_reg == '0);
            stb_right_reg  <= (ecol_reg == w_m1);
            // entry being written this cycle is read back stale
            stb_fwd_reg    <= stb_valid_reg && (stb_q_reg == col_reg);
            fwd_data_reg   <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
            rd_reg <= lb_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (stb_valid_reg)
            lb_mem[stb_q_reg] <= wr_data;
    end

    assign lb_word = stb_fwd_reg ? fwd_data_reg : rd_reg;
    assign wr_data = {lb_word[7:0], stb_sample_reg};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[3*k]     = win_reg[3*k + 1];
            win_next[3*k + 1] = win_reg[3*k + 2];
        end
        win_next[2] = lb_word[15:8];
        win_next[5] = lb_word[7:0];
        win_next[8] = stb_sample_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
        end
        else if (stb_valid_reg)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= win_next[k];
        end
    end

    always_comb
    begin
        q_push.valid = stb_emit_reg;
        q_push.data.a = (stb_top_reg || stb_left_reg)  ? '0 : win_next[0];
        q_push.data.b = stb_top_reg                    ? '0 : win_next[1];
        q_push.data.c = (stb_top_reg || stb_right_reg) ? '0 : win_next[2];
        q_push.data.d = stb_left_reg                   ? '0 : win_next[3];
        q_push.data.e = win_next[4];
        q_push.data.f = stb_right_reg                  ? '0 : win_next[5];
        q_push.data.g = (stb_bot_reg || stb_left_reg)  ? '0 : win_next[6];
        q_push.data.h = stb_bot_reg                    ? '0 : win_next[7];
        q_push.data.i = (stb_bot_reg || stb_right_reg) ? '0 : win_next[8];
        q_push.data.center_row = stb_row_reg;
        q_push.data.center_col = stb_col_reg;
        q_push.data.frame_last = stb_last_reg;
    end

endmodule

// File: hw/rtl/scx3_queue.sv
// Short queue of neighbourhoods between front end and rule stage.
module scx3_queue
    import scx3_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_push_t q_push,
    input  logic    q_pop,
    output nbhd_t   head,
    output q_stat_t q_stat
);

    nbhd_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign do_pop = q_pop && (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (q_push.valid)
            entry_reg[wr_ptr_reg] <= q_push.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_push.valid)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QPTR_W'(1);
            if (q_push.valid && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (!q_push.valid && do_pop)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    assign head              = entry_reg[rd_ptr_reg];
    assign q_stat.head_valid = (count_reg != '0);
    assign q_stat.count      = count_reg;

endmodule

// File: hw/rtl/scx3_back.sv
// Back end: Scale3x rules and the output register.
module scx3_back
    import scx3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  nbhd_t     head,
    input  q_stat_t   q_stat,
    output logic      q_pop,
    input  logic      pop,
    output logic      empty,
    output out_word_t dout
);

    logic      out_valid_reg;
    out_word_t dout_reg;
    out_word_t blk;
    logic      load;

    always_comb
    begin
        blk.out_top_left  = head.e;
        blk.out_top_mid   = head.e;
        blk.out_top_right = head.e;
        blk.out_mid_left  = head.e;
        blk.out_center    = head.e;
        blk.out_mid_right = head.e;
        blk.out_bot_left  = head.e;
        blk.out_bot_mid   = head.e;
        blk.out_bot_right = head.e;
        if ((head.b != head.h) && (head.d != head.f))
        begin
            if (head.d == head.b)
                blk.out_top_left = head.d;
            if (((head.d == head.b) && (head.e != head.c))
                || ((head.b == head.f) && (head.e != head.a)))
                blk.out_top_mid = head.b;
            if (head.b == head.f)
                blk.out_top_right = head.f;
            if (((head.d == head.b) && (head.e != head.g))
                || ((head.d == head.h) && (head.e != head.a)))
                blk.out_mid_left = head.d;
            if (((head.b == head.f) && (head.e != head.i))
                || ((head.h == head.f) && (head.e != head.c)))
                blk.out_mid_right = head.f;
            if (head.d == head.h)
                blk.out_bot_left = head.d;
            if (((head.d == head.h) && (head.e != head.i))
                || ((head.h == head.f) && (head.e != head.g)))
                blk.out_bot_mid = head.h;
            if (head.h == head.f)
                blk.out_bot_right = head.f;
        end
        blk.center_row = head.center_row;
        blk.center_col = head.center_col;
        blk.frame_last = head.frame_last;
    end

    assign load  = q_stat.head_valid && (!out_valid_reg || pop);
    assign q_pop = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            dout_reg <= blk;
    end

    assign empty = !out_valid_reg;
    assign dout  = dout_reg;

endmodule

// File: hw/rtl/scale3x_pixel_upscaler_core.sv
// Top level of the Scale3x pixel upscaler: register port and block wiring.
//
// Input queue side: din carries op and pixel; a word is taken on a clock
// edge with push high and full low. Pixels arrive in raster order, frame
// size set by frame_width (0x0) and frame_height (0x4) on the APB port.
// Output queue side: dout holds the oldest 3x3 block while empty is low; it
// is taken on a clock edge with pop high.
// Each block is centred on the pixel W+1 words earlier; W+1 flush words after
// the last pixel drain the bottom row. A block is held in the front end's
// staging registers, then the queue, then the output register that drives dout.
// One word per clock is taken while full is low; the line buffer RAM has one
// read and one write port, read at accept and written in the cycle after, with
// a bypass when the same column is read straight back.
// When the output is not popped, full rises once five block-producing words
// are held (one in the output register, four queued); nothing is dropped.
// Reset returns the registers to 128 x 64, empties the pipeline and starts a
// new frame; line buffer contents are left as they were and never observed.
// A register write also restarts the frame.
module scale3x_pixel_upscaler_core
    import scx3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  in_word_t           din,
    output logic               empty,
    input  logic               pop,
    output out_word_t          dout
);

    logic [8:0]  width_reg;
    logic [10:0] height_reg;
    logic        cfg_wr;

    q_push_t     q_push;
    q_stat_t     q_stat;
    nbhd_t       q_head;
    logic        q_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_WIDTH_RESET;
            height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_IDX_WIDTH:  width_reg  <= pwdata[8:0];
                REG_IDX_HEIGHT: height_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_IDX_WIDTH:  prdata = {23'b0, width_reg};
            REG_IDX_HEIGHT: prdata = {21'b0, height_reg};
            default:        prdata = '0;
        endcase
    end

    scx3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .restart      (cfg_wr),
        .push         (push),
        .full         (full),
        .din          (din),
        .q_stat       (q_stat),
        .q_push       (q_push)
    );

    scx3_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_pop  (q_pop),
        .head   (q_head),
        .q_stat (q_stat)
    );

    scx3_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .q_stat (q_stat),
        .q_pop  (q_pop),
        .pop    (pop),
        .empty  (empty),
        .dout   (dout)
    );

endmodule

// File: hw/rtl/scx3_checker.sv
// Port-level checks for the Scale3x upscaler, bound to the top level.
module scx3_checker
    import scx3_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready,
    input logic               push,
    input logic               full,
    input in_word_t           din,
    input logic               empty,
    input logic               pop,
    input out_word_t          dout
);

    // no word survives reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("output not empty during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(dout)))
        else $error("stalled output word changed");

    // Scale3x never alters two adjacent corners of a block at once
    a_corner_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (!((dout.out_top_left != dout.out_center)
                      && (dout.out_top_right != dout.out_center))
                    && !((dout.out_bot_left != dout.out_center)
                      && (dout.out_bot_right != dout.out_center))
                    && !((dout.out_top_left != dout.out_center)
                      && (dout.out_bot_left != dout.out_center))
                    && !((dout.out_top_right != dout.out_center)
                      && (dout.out_bot_right != dout.out_center))))
        else $error("conflicting corner pixels in block");

    a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[2] == REG_IDX_WIDTH))
        ##1 (paddr[2] == REG_IDX_WIDTH) |-> (prdata[8:0] == $past(pwdata[8:0])))
        else $error("frame width read back wrong");

endmodule

bind scale3x_pixel_upscaler_core scx3_checker u_scx3_checker (.*);

// File: tb/tb_scale3x_pixel_upscaler_core.sv
// Self-checking testbench for the Scale3x pixel upscaler core.
module tb_scale3x_pixel_upscaler_core;
    timeunit 1ns;
    timeprecision 1ps;

    import scx3_pkg::*;

    localparam int unsigned LIMIT_W = DEF_MAX_WIDTH;
    localparam int unsigned LIMIT_H = DEF_MAX_HEIGHT;

    typedef enum int unsigned {POP_ALWAYS, POP_COIN, POP_SPARSE, POP_HOLD} pop_style_t;

    // Tracks frame position, line buffers and window; holds the blocks still owed.
    class upscale_tracker;
        logic [8:0]  width_reg;
        logic [10:0] height_reg;
        pix_t        line_above [LIMIT_W];
        pix_t        line_current [LIMIT_W];
        pix_t        win [9];
        int unsigned items_seen;
        int unsigned emit_row;
        int unsigned emit_col;
        out_word_t   expected_blocks [$];
        int unsigned mismatches;

        function new();
            width_reg  = FRAME_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            foreach (line_above[k]) line_above[k] = '0;
            foreach (line_current[k]) line_current[k] = '0;
            foreach (win[k]) win[k] = '0;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            items_seen = 0;
            emit_row   = 0;
            emit_col   = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
            return (v < 1) ? 1 : ((v > maxv) ? maxv : v);
        endfunction

        function void write_reg(logic idx, logic [31:0] value);
            if (idx == REG_IDX_WIDTH)
                width_reg = value[8:0];
            else
                height_reg = value[10:0];
            restart();
        endfunction

        function int unsigned pending();
            return expected_blocks.size();
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void take_word(in_word_t word);
            int unsigned wd, ht, total, p, q, r, c;
            pix_t        sample, col_top, col_mid;
            pix_t        a, b, cc, d, e, f, g, hh, i;
            bit          keep, last;
            out_word_t   blk;
            wd    = clamp_dim(width_reg, LIMIT_W);
            ht    = clamp_dim(height_reg, LIMIT_H);
            total = wd * ht;
            p     = items_seen;
            if (p < total && word.op == OP_FLUSH)
                return;
            sample = (p < total) ? word.pixel : 8'd0;

            q       = p % wd;
            col_top = line_above[q];
            col_mid = line_current[q];
            line_above[q]   = col_mid;
            line_current[q] = sample;
            for (int k = 0; k < 3; k++)
            begin
                win[k*3]   = win[k*3+1];
                win[k*3+1] = win[k*3+2];
            end
            win[2] = col_top;
            win[5] = col_mid;
            win[8] = sample;
            items_seen = p + 1;
            if (p < wd + 1)
                return;

            r  = emit_row;
            c  = emit_col;
            a  = (r == 0 || c == 0) ? 8'd0 : win[0];
            b  = (r == 0) ? 8'd0 : win[1];
            cc = (r == 0 || c == wd - 1) ? 8'd0 : win[2];
            d  = (c == 0) ? 8'd0 : win[3];
            e  = win[4];
            f  = (c == wd - 1) ? 8'd0 : win[5];
            g  = (r == ht - 1 || c == 0) ? 8'd0 : win[6];
            hh = (r == ht - 1) ? 8'd0 : win[7];
            i  = (r == ht - 1 || c == wd - 1) ? 8'd0 : win[8];

            keep = (b == hh) || (d == f);
            blk.out_top_left  = (!keep && d == b) ? d : e;
            blk.out_top_mid   = (!keep && ((d == b && e != cc) || (b == f && e != a))) ? b : e;
            blk.out_top_right = (!keep && b == f) ? f : e;
            blk.out_mid_left  = (!keep && ((d == b && e != g) || (d == hh && e != a))) ? d : e;
            blk.out_center    = e;
            blk.out_mid_right = (!keep && ((b == f && e != i) || (hh == f && e != cc))) ? f : e;
            blk.out_bot_left  = (!keep && d == hh) ? d : e;
            blk.out_bot_mid   = (!keep && ((d == hh && e != i) || (hh == f && e != g))) ? hh : e;
            blk.out_bot_right = (!keep && hh == f) ? f : e;
            last = (r == ht - 1) && (c == wd - 1);
            blk.center_row = 10'(r);
            blk.center_col = 8'(c);
            blk.frame_last = last;
            expected_blocks.push_back(blk);

            if (last)
                restart();
            else if (c + 1 >= wd)
            begin
                emit_col = 0;
                emit_row = r + 1;
            end
            else
                emit_col = c + 1;
        endfunction

        function void unpack_fields(out_word_t x, output int unsigned v [12]);
            v = '{x.out_top_left, x.out_top_mid, x.out_top_right,
                  x.out_mid_left, x.out_center, x.out_mid_right,
                  x.out_bot_left, x.out_bot_mid, x.out_bot_right,
                  x.center_row, x.center_col, x.frame_last};
        endfunction

        function void check_block(out_word_t got);
            out_word_t   want;
            int unsigned wv [12];
            int unsigned gv [12];
            bit          bad;
            string       tag [12] = '{"top_left", "top_mid", "top_right", "mid_left",
                                      "center", "mid_right", "bot_left", "bot_mid",
                                      "bot_right", "center_row", "center_col", "frame_last"};
            if (expected_blocks.size() == 0)
            begin
                flag($sformatf("unexpected word out: %h", got));
                return;
            end
            want = expected_blocks.pop_front();
            unpack_fields(want, wv);
            unpack_fields(got, gv);
            bad = 1'b0;
            foreach (wv[k])
                if ($isunknown(got) || wv[k] != gv[k])
                    bad = 1'b1;
            if (!bad)
                return;
            flag($sformatf("mismatch at row %0d col %0d", want.center_row, want.center_col));
            if (mismatches <= 10)
                foreach (wv[k])
                    if (wv[k] != gv[k])
                        $display("  %s: expected %0d, got %0d", tag[k], wv[k], gv[k]);
        endfunction
    endclass

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               push    = 1'b0;
    logic               full;
    in_word_t           din     = '0;
    logic               empty;
    logic               pop     = 1'b0;
    out_word_t          dout;

    upscale_tracker tracker = new();
    int unsigned    burst_left   = 0;
    int unsigned    random_items = 0;
    pop_style_t     pop_style    = POP_ALWAYS;
    int unsigned    pop_left     = 0;

    scale3x_pixel_upscaler_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .full    (full),
        .din     (din),
        .empty   (empty),
        .pop     (pop),
        .dout    (dout)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            tracker.check_block(dout);
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (pop_left == 0)
        begin
            pop_style = pop_style_t'($urandom_range(0, 3));
            pop_left  = (pop_style == POP_HOLD) ? $urandom_range(5, 40) : $urandom_range(20, 200);
        end
        pop_left--;
        case (pop_style)
            POP_ALWAYS: pop <= 1'b1;
            POP_COIN:   pop <= 1'($urandom_range(0, 1));
            POP_SPARSE: pop <= ($urandom_range(0, 5) == 0);
            default:    pop <= 1'b0;
        endcase
    end

    task automatic write_reg(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic expect_reg(logic idx, logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'(idx) << 2;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
            tracker.flag($sformatf("register %0d read: expected %0d, got %0d", idx, want, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_frame(int unsigned wd, int unsigned ht);
        write_reg(REG_IDX_WIDTH, 32'(wd));
        write_reg(REG_IDX_HEIGHT, 32'(ht));
        expect_reg(REG_IDX_WIDTH, 32'(9'(wd)));
        expect_reg(REG_IDX_HEIGHT, 32'(11'(ht)));
    endtask

    task automatic send_word(logic op, pix_t value);
        in_word_t w;
        w.op    = op;
        w.pixel = value;
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 40);
        end
        push <= 1'b1;
        din  <= w;
        do @(posedge clk); while (full);
        tracker.take_word(w);
        burst_left--;
    endtask

    task automatic wait_drained(int unsigned settle);
        push <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // one frame of pixels then its drain; noisy frames carry stray and broken items
    task automatic send_frame(int unsigned wd, int unsigned ht, bit noisy);
        pix_t        pal [3];
        int unsigned mode, drains;
        pix_t        value;
        mode = $urandom_range(0, 4);
        foreach (pal[k])
            pal[k] = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom);
        for (int unsigned n = 0; n < wd * ht; n++)
        begin
            if (noisy && $urandom_range(0, 30) == 0)
                send_word(OP_FLUSH, 8'($urandom));
            if (mode < 2)
                value = pal[$urandom_range(0, 1)];
            else if (mode < 4)
                value = pal[$urandom_range(0, 2)];
            else
                value = 8'($urandom);
            send_word(OP_PIXEL, value);
            random_items++;
            if (noisy && $urandom_range(0, 150) == 0)
                wait_drained(0);
        end
        drains = wd + 1;
        if (noisy && $urandom_range(0, 9) == 0)
            drains = $urandom_range(0, wd + 3);
        repeat (drains)
            send_word(($urandom_range(0, 7) == 0) ? OP_PIXEL : OP_FLUSH, 8'($urandom));
    endtask

    initial
    begin
        int unsigned wd, ht;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        expect_reg(REG_IDX_WIDTH, 32'(FRAME_WIDTH_RESET));
        expect_reg(REG_IDX_HEIGHT, 32'(FRAME_HEIGHT_RESET));

        // 3x2: stray flush at start and mid-frame, pixel in the drain, flush after frame end
        program_frame(3, 2);
        send_word(OP_FLUSH, 8'h5A);
        send_word(OP_PIXEL, 8'h00);
        send_word(OP_PIXEL, 8'hFF);
        send_word(OP_PIXEL, 8'hFF);
        send_word(OP_FLUSH, 8'hFF);
        send_word(OP_PIXEL, 8'h80);
        send_word(OP_PIXEL, 8'h7F);
        send_word(OP_PIXEL, 8'hFF);
        send_word(OP_PIXEL, 8'h11);
        send_word(OP_FLUSH, 8'h00);
        send_word(OP_FLUSH, 8'hAA);
        send_word(OP_FLUSH, 8'h55);
        send_word(OP_FLUSH, 8'h00);
        wait_drained(10);

        // checkerboard for the corner rules
        program_frame(3, 3);
        for (int n = 0; n < 9; n++)
            send_word(OP_PIXEL, (n % 2 == 0) ? 8'h10 : 8'h20);
        repeat (4) send_word(OP_FLUSH, 8'h00);
        wait_drained(10);

        // size extremes, out-of-range values clamped
        program_frame(511, 0);
        send_frame(LIMIT_W, 1, 1'b0);
        wait_drained(10);
        program_frame(0, 0);
        send_frame(1, 1, 1'b0);
        wait_drained(10);

        random_items = 0;
        while (random_items < 300)
        begin
            wd = $urandom_range(1, 10);
            ht = $urandom_range(1, 6);
            if ($urandom_range(0, 7) == 0)
                wd = $urandom_range(11, 40);
            program_frame(wd, ht);
            repeat ($urandom_range(1, 3)) send_frame(wd, ht, 1'b1);
            wait_drained(10);
        end

        wait_drained(20);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
